/* rtl/dsq_pkg.sv */
// Shared constants, types and helpers of the delta-sorted sleep queue.
package dsq_pkg;

  // Sizing
  localparam int ENTRIES   = 64;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  // Fixed word field widths
  localparam int OPCODE_W    = 2;
  localparam int HANDLE_W    = 6;
  localparam int IN_TIME_W   = 16;
  localparam int STATUS_W    = 2;
  localparam int OUT_DELTA_W = 16;
  localparam int OUT_COUNT_W = 7;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POP    = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // One list node as stored in the entry memory
  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [TIME_BITS-1:0] delta;
    logic [IDX_W-1:0]     link;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Slot allocator controls
  typedef struct packed {
    logic             start;
    logic             take;
    logic             push;
    logic [IDX_W-1:0] push_slot;
  } alloc_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_INS_WALK,
    S_INS_WNEW,
    S_INS_WCUR,
    S_WPREV,
    S_REM_WALK,
    S_REM_NX,
    S_POP,
    S_HEAD_RD,
    S_HEAD_DATA
  } state_t;

  // Out-of-range slot indexes read as slot 0
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] x);
    slot_of = (int'(x) < ENTRIES) ? x : '0;
  endfunction

endpackage

/* rtl/dsq_ifc.sv */
// Valid/ready channel interfaces for request and response words.
interface dsq_req_if import dsq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [HANDLE_W-1:0]  handle;
  logic [IN_TIME_W-1:0] sleep_time;

  modport source (output valid, opcode, handle, sleep_time, input ready);
  modport sink   (input valid, opcode, handle, sleep_time, output ready);
endinterface

interface dsq_rsp_if import dsq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [HANDLE_W-1:0]    out_handle;
  logic [OUT_DELTA_W-1:0] head_delta;
  logic [OUT_COUNT_W-1:0] entry_count;

  modport source (output valid, status, out_handle, head_delta, entry_count, input ready);
  modport sink   (input valid, status, out_handle, head_delta, entry_count, output ready);
endinterface

/* rtl/dsq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-cycle write; data holds while idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dsq_slot_alloc.sv */
// Free slot allocator: bump counter for unused slots plus a stack of freed ones.
module dsq_slot_alloc import dsq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  alloc_ctl_t       ctl,
  output logic [IDX_W-1:0] slot
);

  logic [CNT_W-1:0] fresh;      // slots never handed out yet start here
  logic [CNT_W-1:0] sp;         // freed slots on the stack
  logic             use_fresh;
  logic [IDX_W-1:0] stk_rdata;

  // Freed slot stack
  dsq_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_stack (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (sp[IDX_W-1:0]),
    .wdata (ctl.push_slot),
    .re    (ctl.start),
    .raddr (IDX_W'(sp - 1'b1)),
    .rdata (stk_rdata)
  );

  assign slot = use_fresh ? fresh[IDX_W-1:0] : stk_rdata;

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh     <= '0;
      sp        <= '0;
      use_fresh <= 1'b1;
    end else begin
      if (ctl.start) begin
        use_fresh <= (int'(fresh) < ENTRIES);
      end
      if (ctl.take) begin
        if (use_fresh) begin
          fresh <= fresh + 1'b1;
        end else begin
          sp <= sp - 1'b1;
        end
      end else if (ctl.push) begin
        sp <= sp + 1'b1;
      end
    end
  end

endmodule

/* rtl/delta_sorted_sleep_queue_unit.sv */
// Top level of the delta-sorted sleep queue: list walker and entry memory.
//
// Holds up to ENTRIES sleeping thread handles as a linked delta list in
// one entry memory; each node keeps its wake time relative to the node
// before it. Requests arrive on req (opcode, handle, sleep_time) and each
// gives exactly one response word on rsp (status, out_handle, head_delta,
// entry_count).
// Timing: the list walk reads one node of the entry memory per cycle.
// An insert writes the new node after its walk, then rewrites its
// successor and its predecessor where they exist; a remove of a node
// that has a successor rewrites that successor and then any predecessor.
// The response word is offered in the same cycle in which the walker
// is ready for the next request. One request is worked on at a time;
// req.ready is high only while the walker waits for a request.
// A response sits in an output register, so the next request is taken
// while it waits; if rsp stays stalled, the walker holds its finished
// result and stops taking requests until the register frees.
// Reset (synchronous, rst high) empties the queue and drops any pending
// response; no memory clearing pass is needed.
module delta_sorted_sleep_queue_unit import dsq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dsq_req_if.sink   req,
  dsq_rsp_if.source rsp
);

  state_t state, state_next;

  // Queue state
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;

  // Working registers of one request
  logic [OPCODE_W-1:0]  op;
  logic [HANDLE_W-1:0]  hnd;
  logic [TIME_BITS-1:0] t_rem;
  logic [CNT_W-1:0]     walked;
  logic [IDX_W-1:0]     cur;
  logic [IDX_W-1:0]     prev;
  logic [IDX_W-1:0]     prev_link;
  logic [IDX_W-1:0]     nx_slot;
  logic                 have_prev;
  logic                 cur_exists;
  entry_t               prev_rec;
  entry_t               cur_rec;
  logic [STATUS_W-1:0]  status_r;
  logic [HANDLE_W-1:0]  got;

  // Response register
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [HANDLE_W-1:0]    out_hnd;
  logic [OUT_DELTA_W-1:0] out_delta;
  logic [OUT_COUNT_W-1:0] out_count;

  // Entry memory ports
  logic             e_we;
  logic [IDX_W-1:0] e_waddr;
  entry_t           e_wdata;
  logic             e_re;
  logic [IDX_W-1:0] e_raddr;
  logic [ENTRY_W-1:0] e_rdata;
  entry_t           rd;

  alloc_ctl_t       alloc;
  logic [IDX_W-1:0] alloc_slot;

  logic             full;
  logic             adv_ins;
  logic             adv_rem;
  logic             found;
  logic             last;
  logic             load;
  logic [TIME_BITS:0]   carry_sum;
  logic [TIME_BITS-1:0] carry_sat;

  dsq_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entries (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  dsq_slot_alloc u_alloc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alloc),
    .slot (alloc_slot)
  );

  // Walk decisions on the node just read
  assign rd      = entry_t'(e_rdata);
  assign full    = (int'(count) >= ENTRIES);
  assign adv_ins = (walked < count) && (rd.delta <= t_rem);
  assign adv_rem = (walked < count) && (rd.handle != hnd);
  assign found   = (walked < count);
  assign last    = !(CNT_W'(walked + 1'b1) < count);
  assign load    = !out_valid || rsp.ready;

  // Carry of a removed delta into its successor, saturating
  assign carry_sum = {1'b0, rd.delta} + {1'b0, cur_rec.delta};
  assign carry_sat = carry_sum[TIME_BITS] ? '1 : carry_sum[TIME_BITS-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_START;
      end
      S_START: begin
        case (op)
          OP_INSERT: state_next = full ? S_HEAD_RD : S_INS_WALK;
          OP_REMOVE: state_next = S_REM_WALK;
          OP_POP:    state_next = (count == '0) ? S_HEAD_RD : S_POP;
          default:   state_next = S_HEAD_RD;
        endcase
      end
      S_INS_WALK: begin
        if (!adv_ins) state_next = S_INS_WNEW;
      end
      S_INS_WNEW: begin
        if (cur_exists)     state_next = S_INS_WCUR;
        else if (have_prev) state_next = S_WPREV;
        else                state_next = S_HEAD_RD;
      end
      S_INS_WCUR: state_next = have_prev ? S_WPREV : S_HEAD_RD;
      S_WPREV:    state_next = S_HEAD_RD;
      S_REM_WALK: begin
        if (!adv_rem) begin
          state_next = (found && !last) ? S_REM_NX : S_HEAD_RD;
        end
      end
      S_REM_NX:    state_next = have_prev ? S_WPREV : S_HEAD_RD;
      S_POP:       state_next = S_HEAD_RD;
      S_HEAD_RD:   state_next = S_HEAD_DATA;
      S_HEAD_DATA: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory and allocator controls
  always_comb begin
    e_we            = 1'b0;
    e_waddr         = cur;
    e_wdata         = cur_rec;
    e_re            = 1'b0;
    e_raddr         = head;
    alloc.start     = 1'b0;
    alloc.take      = 1'b0;
    alloc.push      = 1'b0;
    alloc.push_slot = cur;
    unique case (state)
      S_START: begin
        e_re        = 1'b1;
        alloc.start = (op == OP_INSERT) && !full;
      end
      S_INS_WALK: begin
        e_re    = adv_ins;
        e_raddr = slot_of(rd.link);
      end
      S_INS_WNEW: begin
        e_we           = 1'b1;
        e_waddr        = alloc_slot;
        e_wdata.handle = hnd;
        e_wdata.delta  = t_rem;
        e_wdata.link   = cur_exists ? cur : '0;
        alloc.take     = 1'b1;
      end
      S_INS_WCUR: begin
        e_we          = 1'b1;
        e_wdata.delta = cur_rec.delta - t_rem;
      end
      S_WPREV: begin
        e_we         = 1'b1;
        e_waddr      = prev;
        e_wdata      = prev_rec;
        e_wdata.link = prev_link;
      end
      S_REM_WALK: begin
        e_re       = adv_rem || (found && !last);
        e_raddr    = slot_of(rd.link);
        alloc.push = !adv_rem && found;
      end
      S_REM_NX: begin
        e_we          = 1'b1;
        e_waddr       = nx_slot;
        e_wdata       = rd;
        e_wdata.delta = carry_sat;
      end
      S_POP: begin
        alloc.push      = 1'b1;
        alloc.push_slot = head;
      end
      S_HEAD_RD: begin
        e_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_INS_WNEW: begin
          count <= count + 1'b1;
          if (!have_prev) head <= alloc_slot;
        end
        S_REM_WALK: begin
          if (!adv_rem && found) begin
            count <= count - 1'b1;
            if (last && !have_prev) head <= '0;
          end
        end
        S_REM_NX: begin
          if (!have_prev) head <= nx_slot;
        end
        S_POP: begin
          count <= count - 1'b1;
          head  <= (count == CNT_W'(1)) ? '0 : slot_of(rd.link);
        end
        default: begin
        end
      endcase
      if (state == S_HEAD_DATA && load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and response registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op       <= req.opcode;
        hnd      <= req.handle;
        t_rem    <= TIME_BITS'(req.sleep_time);
        status_r <= ST_DONE;
        got      <= '0;
      end
      S_START: begin
        cur       <= head;
        walked    <= '0;
        have_prev <= 1'b0;
        if (op == OP_INSERT && full) status_r <= ST_FULL;
        if (op == OP_POP && count == '0) status_r <= ST_MISS;
      end
      S_INS_WALK: begin
        if (adv_ins) begin
          t_rem     <= t_rem - rd.delta;
          prev      <= cur;
          prev_rec  <= rd;
          have_prev <= 1'b1;
          cur       <= slot_of(rd.link);
          walked    <= walked + 1'b1;
        end else begin
          cur_rec    <= rd;
          cur_exists <= (walked != count);
        end
      end
      S_INS_WNEW: begin
        prev_link <= alloc_slot;
      end
      S_REM_WALK: begin
        if (adv_rem) begin
          prev      <= cur;
          prev_rec  <= rd;
          have_prev <= 1'b1;
          cur       <= slot_of(rd.link);
          walked    <= walked + 1'b1;
        end else if (!found) begin
          status_r <= ST_MISS;
        end else begin
          cur_rec   <= rd;
          nx_slot   <= slot_of(rd.link);
          prev_link <= slot_of(rd.link);
        end
      end
      S_POP: begin
        got <= rd.handle;
      end
      S_HEAD_DATA: begin
        if (load) begin
          out_status <= status_r;
          out_hnd    <= got;
          out_delta  <= (count != '0) ? OUT_DELTA_W'(rd.delta) : '0;
          out_count  <= OUT_COUNT_W'(count);
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.out_handle  = out_hnd;
  assign rsp.head_delta  = out_delta;
  assign rsp.entry_count = out_count;

endmodule

/* rtl/dsq_checker.sv */
// Port-level checks of the sleep queue and their binding to the top level.
module dsq_checker import dsq_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [STATUS_W-1:0]    status,
  input logic [HANDLE_W-1:0]    out_handle,
  input logic [OUT_COUNT_W-1:0] entry_count
);

  // A stalled response word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // Reset leaves no response pending
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response pending after reset");

  // A full report only comes with every slot in use
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_count == OUT_COUNT_W'(ENTRIES))
    else $error("full status with free slots");

  // Only a successful operation returns a handle
  a_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_DONE |-> out_handle == '0)
    else $error("handle returned on failed operation");

endmodule

bind delta_sorted_sleep_queue_unit dsq_checker u_dsq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .out_handle  (rsp.out_handle),
  .entry_count (rsp.entry_count)
);

/* tb/tb_top.sv */
// Self-checking testbench of the delta-sorted sleep queue: directed and random sleep requests.
module tb_top import dsq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [HANDLE_W-1:0]  handle;
    logic [IN_TIME_W-1:0] sleep_time;
  } sleep_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [HANDLE_W-1:0]    out_handle;
    logic [OUT_DELTA_W-1:0] head_delta;
    logic [OUT_COUNT_W-1:0] entry_count;
  } queue_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Local drivers of the channel inputs, known from time zero
  logic      req_valid = 1'b0;
  sleep_op_t req_word  = '0;
  logic      rsp_ready = 1'b0;

  dsq_req_if req_if ();
  dsq_rsp_if rsp_if ();

  assign req_if.valid      = req_valid;
  assign req_if.opcode     = req_word.opcode;
  assign req_if.handle     = req_word.handle;
  assign req_if.sleep_time = req_word.sleep_time;
  assign rsp_if.ready      = rsp_ready;

  delta_sorted_sleep_queue_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stimulus words waiting to go out, and replies owed by the block
  sleep_op_t    sleep_ops[$];
  queue_reply_t owed_replies[$];
  int           words_sent = 0;
  int           fail_count = 0;

  // Shadow delta list
  logic [HANDLE_W-1:0]  lst_handle[ENTRIES];
  logic [TIME_BITS-1:0] lst_delta[ENTRIES];
  logic [IDX_W-1:0]     lst_link[ENTRIES];
  logic [IDX_W-1:0]     lst_head;
  logic [ENTRIES-1:0]   lst_free;
  int                   lst_count;

  // Apply one request to the shadow list and return the reply it must produce
  function automatic queue_reply_t apply_sleep_op(sleep_op_t op);
    queue_reply_t         r;
    int                   s;
    int                   pos;
    logic [IDX_W-1:0]     cur;
    logic [IDX_W-1:0]     prev;
    logic [IDX_W-1:0]     nx;
    logic                 have_prev;
    logic [TIME_BITS-1:0] rem;
    logic [TIME_BITS:0]   sum;
    r         = '0;
    prev      = '0;
    have_prev = 1'b0;
    pos       = 0;
    cur       = lst_head;
    case (op.opcode)
      OP_INSERT: begin
        if (lst_count >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          s = 0;
          while (s < ENTRIES && !lst_free[s]) s++;
          rem = TIME_BITS'(op.sleep_time);
          // pass every node whose delta fits, so equal times stay in arrival order
          while (pos < lst_count && lst_delta[cur] <= rem) begin
            rem       = rem - lst_delta[cur];
            prev      = cur;
            have_prev = 1'b1;
            cur       = lst_link[cur];
            pos++;
          end
          lst_handle[s] = op.handle;
          lst_delta[s]  = rem;
          if (pos == lst_count) begin
            lst_link[s] = '0;
          end else begin
            lst_link[s]    = cur;
            lst_delta[cur] = lst_delta[cur] - rem;
          end
          if (have_prev) lst_link[prev] = IDX_W'(s);
          else lst_head = IDX_W'(s);
          lst_free[s] = 1'b0;
          lst_count++;
        end
      end
      OP_REMOVE: begin
        while (pos < lst_count && lst_handle[cur] != op.handle) begin
          prev      = cur;
          have_prev = 1'b1;
          cur       = lst_link[cur];
          pos++;
        end
        if (pos >= lst_count) begin
          r.status = ST_MISS;
        end else begin
          if (pos + 1 < lst_count) begin
            // successor inherits the removed delta, saturating
            nx            = lst_link[cur];
            sum           = {1'b0, lst_delta[nx]} + lst_delta[cur];
            lst_delta[nx] = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
            if (have_prev) lst_link[prev] = nx;
            else lst_head = nx;
          end else if (!have_prev) begin
            lst_head = '0;
          end
          lst_free[cur] = 1'b1;
          lst_count--;
        end
      end
      OP_POP: begin
        if (lst_count == 0) begin
          r.status = ST_MISS;
        end else begin
          r.out_handle       = lst_handle[lst_head];
          lst_free[lst_head] = 1'b1;
          lst_count--;
          lst_head = (lst_count == 0) ? '0 : lst_link[lst_head];
        end
      end
      default: ;
    endcase
    r.head_delta  = (lst_count != 0) ? OUT_DELTA_W'(lst_delta[lst_head]) : '0;
    r.entry_count = OUT_COUNT_W'(lst_count);
    return r;
  endfunction

  function automatic void queue_op(logic [OPCODE_W-1:0] opc, int h, int t);
    sleep_op_t w;
    w.opcode     = opc;
    w.handle     = HANDLE_W'(h);
    w.sleep_time = IN_TIME_W'(t);
    sleep_ops.push_back(w);
  endfunction

  // Random request; handles lean toward a small pool so removes often hit
  function automatic sleep_op_t random_op(int insert_pct);
    sleep_op_t w;
    int        pick;
    w.handle = ($urandom_range(0, 9) < 6) ? HANDLE_W'($urandom_range(0, 7))
                                          : HANDLE_W'($urandom_range(0, 63));
    case ($urandom_range(0, 2))
      0:       w.sleep_time = IN_TIME_W'($urandom_range(0, 15));
      1:       w.sleep_time = IN_TIME_W'($urandom_range(0, 2000));
      default: w.sleep_time = IN_TIME_W'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) begin
      w.opcode = OP_INSERT;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 11) w.opcode = OP_REMOVE;
      else if (pick < 19) w.opcode = OP_POP;
      else w.opcode = OP_UNUSED;
    end
    return w;
  endfunction

  // Request driver: bursts of words with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (req_valid && req_if.ready) begin
        owed_replies.push_back(apply_sleep_op(req_word));
        words_sent <= words_sent + 1;
      end
      if (!req_valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (sleep_ops.size() > 0) begin
          req_word  <= sleep_ops.pop_front();
          req_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off once traffic is well under way
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_sent >= 600) begin
      hold_left <= 500;
      hold_done <= 1'b1;
    end
  end

  // Reply monitor and receiver stall pattern
  int pat_mode  = 0;
  int pat_left  = 0;
  int pat_phase = 0;

  always @(posedge clk) begin : reply_check
    queue_reply_t got;
    queue_reply_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ready && rsp_if.valid) begin
        got = {rsp_if.status, rsp_if.out_handle, rsp_if.head_delta, rsp_if.entry_count};
        if (owed_replies.size() == 0) begin
          $error("reply word with no request outstanding");
          fail_count++;
        end else begin
          want = owed_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.out_handle !== want.out_handle) begin
            $error("out_handle expected %0d got %0d", want.out_handle, got.out_handle);
            fail_count++;
          end
          if (got.head_delta !== want.head_delta) begin
            $error("head_delta expected %0d got %0d", want.head_delta, got.head_delta);
            fail_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count expected %0d got %0d", want.entry_count, got.entry_count);
            fail_count++;
          end
        end
      end
      // mode 0 always ready, 1 coin flip, 2 a repeating ready pattern set by pat_phase
      if (pat_left == 0) begin
        pat_mode <= $urandom_range(0, 2);
        pat_left <= $urandom_range(20, 300);
      end else begin
        pat_left <= pat_left - 1;
      end
      pat_phase <= pat_phase + 1;
      rsp_ready <= (hold_left == 0) &&
                   ((pat_mode == 0) ||
                    (pat_mode == 1 && $urandom_range(0, 1) == 1) ||
                    (pat_mode == 2 && (pat_phase % 5) < 2));
    end
  end

  // Stimulus, reset and end of run
  initial begin : main
    int i;
    int pct;
    int len;
    for (i = 0; i < ENTRIES; i++) begin
      lst_handle[i] = '0;
      lst_delta[i]  = '0;
      lst_link[i]   = '0;
    end
    lst_head  = '0;
    lst_free  = '1;
    lst_count = 0;

    // empty queue cases
    queue_op(OP_POP, 0, 0);
    queue_op(OP_REMOVE, 9, 0);
    queue_op(OP_UNUSED, 0, 0);
    // ordering, equal times, duplicate handles, extremes of time and handle
    queue_op(OP_INSERT, 5, 100);
    queue_op(OP_INSERT, 63, 65535);
    queue_op(OP_INSERT, 5, 100);
    queue_op(OP_INSERT, 0, 0);
    queue_op(OP_INSERT, 12, 100);
    queue_op(OP_INSERT, 7, 50);
    queue_op(OP_REMOVE, 40, 0);
    queue_op(OP_REMOVE, 5, 0);
    queue_op(OP_REMOVE, 63, 0);
    queue_op(OP_REMOVE, 0, 0);
    queue_op(OP_UNUSED, 63, 65535);
    queue_op(OP_POP, 63, 65535);
    queue_op(OP_POP, 0, 0);
    queue_op(OP_POP, 0, 0);
    queue_op(OP_POP, 0, 0);
    // only entry removed, then only entry popped
    queue_op(OP_INSERT, 33, 65535);
    queue_op(OP_REMOVE, 33, 0);
    queue_op(OP_INSERT, 21, 1);
    queue_op(OP_POP, 0, 0);

    // random phases: fill to full first, then mixed fill levels
    pct = 95;
    len = 140;
    while (sleep_ops.size() < 1420) begin
      for (i = 0; i < len; i++) sleep_ops.push_back(random_op(pct));
      case ($urandom_range(0, 2))
        0:       pct = 90;
        1:       pct = 50;
        default: pct = 15;
      endcase
      len = $urandom_range(30, 150);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (sleep_ops.size() > 0 || req_valid) @(posedge clk);
    while (owed_replies.size() > 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/dsq_pkg.sv
rtl/dsq_ifc.sv
rtl/dsq_ram.sv
rtl/dsq_slot_alloc.sv
rtl/delta_sorted_sleep_queue_unit.sv
rtl/dsq_checker.sv
tb/tb_top.sv
